/* rtl/rnpr_pkg.sv */
// Package for the rope node pair repulsion block.
// Holds payload structs, register indexes, sequencer states and constants.
// No dependencies.
package rnpr_pkg;

   localparam int MaxNodes  = 32;
   localparam int PosW      = 32;
   localparam int FrcW      = 40;
   localparam int RadW      = 25;
   localparam int GainW     = 16;

   localparam logic [1:0] ActLoadA = 2'd0;
   localparam logic [1:0] ActLoadB = 2'd1;
   localparam logic [1:0] ActRun   = 2'd2;

   localparam logic [1:0] RegInner = 2'd0;
   localparam logic [1:0] RegOuter = 2'd1;
   localparam logic [1:0] RegMinSq = 2'd2;
   localparam logic [1:0] RegGain  = 2'd3;

   localparam logic [RadW-1:0]  InnerReset = 25'd335544;
   localparam logic [RadW-1:0]  OuterReset = 25'd838861;
   localparam logic [RadW-1:0]  MinSqReset = 25'd503;
   localparam logic [GainW-1:0] GainReset  = 16'd400;

   typedef struct packed {
      logic [1:0]             action;
      logic signed [PosW-1:0] pos_x;
      logic signed [PosW-1:0] pos_y;
      logic signed [PosW-1:0] pos_z;
      logic signed [FrcW-1:0] force_x;
      logic signed [FrcW-1:0] force_y;
      logic signed [FrcW-1:0] force_z;
   } req_type;

   typedef struct packed {
      logic                   rope_sel;
      logic [4:0]             node_index;
      logic signed [PosW-1:0] out_x;
      logic signed [PosW-1:0] out_y;
      logic signed [PosW-1:0] out_z;
      logic signed [FrcW-1:0] out_fx;
      logic signed [FrcW-1:0] out_fy;
      logic signed [FrcW-1:0] out_fz;
      logic                   last;
   } rsp_type;

   // node record as stored in memory
   typedef struct packed {
      logic signed [PosW-1:0] px;
      logic signed [PosW-1:0] py;
      logic signed [PosW-1:0] pz;
      logic signed [FrcW-1:0] fx;
      logic signed [FrcW-1:0] fy;
      logic signed [FrcW-1:0] fz;
   } node_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_DIFF,
      ST_SQ,
      ST_SUM,
      ST_CHK,
      ST_DIV,
      ST_KSQ,
      ST_SGAIN,
      ST_FMUL,
      ST_SQRT,
      ST_CMUL,
      ST_CDIV,
      ST_WB,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   function automatic logic signed [FrcW-1:0] sat_frc(input logic signed [FrcW+1:0] v);
      logic signed [FrcW+1:0] hi;
      logic signed [FrcW+1:0] lo;
      hi = {3'b000, {(FrcW-1){1'b1}}};
      lo = {3'b111, {(FrcW-1){1'b0}}};
      if (v > hi) return hi[FrcW-1:0];
      if (v < lo) return lo[FrcW-1:0];
      return v[FrcW-1:0];
   endfunction

   function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
      logic signed [PosW+1:0] hi;
      logic signed [PosW+1:0] lo;
      hi = {3'b000, {(PosW-1){1'b1}}};
      lo = {3'b111, {(PosW-1){1'b0}}};
      if (v > hi) return hi[PosW-1:0];
      if (v < lo) return lo[PosW-1:0];
      return v[PosW-1:0];
   endfunction

endpackage

/* rtl/rope_node_pair_repulsion_top.sv */
// Rope node pair repulsion top level: node memories, pair sequencer, emitter.
// Depends on rnpr_pkg, rnpr_divider and rnpr_sqrt.
// Loads are written while idle and may follow back to back. A run is accepted while
// idle; each pair is then read, differenced, squared and summed, and written back
// when far or skipped, after the falloff divide in repulsion, or after the square
// root and a divide per axis in contact (none at zero length), then emits each node.
// busy holds off new items for the whole run; the receiver cannot stall results.
// Reset clears counts, registers to defaults; node memories are not cleared.
module rope_node_pair_repulsion_top #(
   parameter int MAX_NODES = rnpr_pkg::MaxNodes
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rnpr_pkg::req_type req_data,
   output logic              rsp_valid,
   output rnpr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   localparam int IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CntW = $clog2(MAX_NODES + 1);
   // falloff numerator is (outer^2 - dl) << 24, up to 74 bits
   localparam int DivW = 74;

   // node memories, one entry per node
   rnpr_pkg::node_type mem_a [MAX_NODES];
   rnpr_pkg::node_type mem_b [MAX_NODES];
   rnpr_pkg::node_type rd_a_ff, rd_b_ff;
   logic [IdxW-1:0] ra_addr, rb_addr;
   logic            wa_en, wb_en;
   logic [IdxW-1:0] wa_addr, wb_addr;
   rnpr_pkg::node_type wa_data, wb_data;

   logic [24:0] inner_ff, outer_ff, minsq_ff;
   logic [15:0] gain_ff;
   logic [CntW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   logic            emb_ff, emb_in;   // emitting rope B
   rnpr_pkg::state_type st_ff, st_in;

   rnpr_pkg::node_type na_ff, na_in, nb_ff, nb_in;
   logic signed [33:0] d_ff [3];
   logic signed [33:0] d_in [3];
   logic [32:0] ad_ff [3];
   logic [32:0] ad_in [3];
   logic [49:0] sq_ff [3];
   logic [49:0] sq_in [3];
   logic [51:0] dl_ff, dl_in;
   logic [49:0] ro2_ff, ri2_ff;
   logic [23:0] k_ff, k_in;
   logic [47:0] kk_ff, kk_in;
   logic [39:0] s_ff, s_in;
   logic [1:0]  ax_ff, ax_in;
   logic [25:0] len_ff, len_in;
   logic [57:0] cm_ff, cm_in;

   logic            dv_start;
   logic [DivW-1:0] dv_num, dv_quo;
   logic [63:0]     dv_den;
   logic            dv_done;
   logic        sq_start;
   logic        sq_done;
   logic [25:0] sq_root;
   logic        far;
   logic        accept;

   rnpr_pkg::rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;

   rnpr_divider #(.NumW(DivW), .DenW(64)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quo(dv_quo)
   );

   rnpr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .rad(dl_ff),
      .done(sq_done), .root(sq_root)
   );

   assign accept    = start && !busy;
   assign busy      = (st_ff != rnpr_pkg::ST_IDLE);
   assign csr_ready = (st_ff == rnpr_pkg::ST_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= rnpr_pkg::InnerReset;
         outer_ff <= rnpr_pkg::OuterReset;
         minsq_ff <= rnpr_pkg::MinSqReset;
         gain_ff  <= rnpr_pkg::GainReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rnpr_pkg::RegInner: inner_ff <= csr_wdata[24:0];
            rnpr_pkg::RegOuter: outer_ff <= csr_wdata[24:0];
            rnpr_pkg::RegMinSq: minsq_ff <= csr_wdata[24:0];
            rnpr_pkg::RegGain:  gain_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
      ro2_ff <= 50'(outer_ff) * 50'(outer_ff);
      ri2_ff <= 50'(inner_ff) * 50'(inner_ff);
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (wa_en) mem_a[wa_addr] <= wa_data;
      if (wb_en) mem_b[wb_addr] <= wb_data;
      rd_a_ff <= mem_a[ra_addr];
      rd_b_ff <= mem_b[rb_addr];
   end

   always_comb begin
      far = 1'b0;
      for (int c = 0; c < 3; c++) begin
         if (ad_ff[c] >= 33'd33554432) far = 1'b1;
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         rnpr_pkg::ST_IDLE:
            if (accept && req_data.action == rnpr_pkg::ActRun) begin
               if (cnt_a_ff != '0 && cnt_b_ff != '0) st_in = rnpr_pkg::ST_RD;
               else if (cnt_a_ff != '0 || cnt_b_ff != '0) st_in = rnpr_pkg::ST_EMIT_RD;
            end
         rnpr_pkg::ST_RD:    st_in = rnpr_pkg::ST_DIFF;
         rnpr_pkg::ST_DIFF:  st_in = rnpr_pkg::ST_SQ;
         rnpr_pkg::ST_SQ:    st_in = rnpr_pkg::ST_SUM;
         rnpr_pkg::ST_SUM:   st_in = far ? rnpr_pkg::ST_WB : rnpr_pkg::ST_CHK;
         rnpr_pkg::ST_CHK:
            if (dl_ff >= 52'(ro2_ff) || dl_ff < (52'(minsq_ff) << 24))
               st_in = rnpr_pkg::ST_WB;
            else if (dl_ff >= 52'(ri2_ff)) st_in = rnpr_pkg::ST_DIV;
            else st_in = rnpr_pkg::ST_SQRT;
         rnpr_pkg::ST_DIV:   if (dv_done) st_in = rnpr_pkg::ST_KSQ;
         rnpr_pkg::ST_KSQ:   st_in = rnpr_pkg::ST_SGAIN;
         rnpr_pkg::ST_SGAIN: st_in = rnpr_pkg::ST_FMUL;
         rnpr_pkg::ST_FMUL:  if (ax_ff == 2'd2) st_in = rnpr_pkg::ST_WB;
         rnpr_pkg::ST_SQRT:  if (sq_done) st_in = rnpr_pkg::ST_CMUL;
         rnpr_pkg::ST_CMUL:  st_in = rnpr_pkg::ST_CDIV;
         rnpr_pkg::ST_CDIV:
            if (len_ff == '0 || dv_done) begin
               if (ax_ff == 2'd2) st_in = rnpr_pkg::ST_WB;
               else st_in = rnpr_pkg::ST_CMUL;
            end
         rnpr_pkg::ST_WB:
            if (j_ff == cnt_b_ff - 1'b1 && i_ff == cnt_a_ff - 1'b1)
               st_in = rnpr_pkg::ST_EMIT_RD;
            else st_in = rnpr_pkg::ST_RD;
         rnpr_pkg::ST_EMIT_RD: st_in = rnpr_pkg::ST_EMIT;
         rnpr_pkg::ST_EMIT:
            if (rsp_in.last) st_in = rnpr_pkg::ST_IDLE;
            else st_in = rnpr_pkg::ST_EMIT_RD;
         default: st_in = rnpr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic signed [33:0] mid;
      logic signed [33:0] tt;
      logic signed [41:0] fv;
      logic [63:0] mag;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      i_in = i_ff;
      j_in = j_ff;
      emb_in = emb_ff;
      na_in = na_ff;
      nb_in = nb_ff;
      d_in = d_ff;
      ad_in = ad_ff;
      sq_in = sq_ff;
      dl_in = dl_ff;
      k_in = k_ff;
      kk_in = kk_ff;
      s_in = s_ff;
      ax_in = ax_ff;
      len_in = len_ff;
      cm_in = cm_ff;
      wa_en = 1'b0;
      wb_en = 1'b0;
      wa_addr = i_ff[IdxW-1:0];
      wb_addr = j_ff[IdxW-1:0];
      wa_data = na_ff;
      wb_data = nb_ff;
      ra_addr = i_ff[IdxW-1:0];
      rb_addr = j_ff[IdxW-1:0];
      dv_start = 1'b0;
      dv_num = '0;
      dv_den = 64'(ro2_ff);
      sq_start = 1'b0;
      rspv_in = 1'b0;
      rsp_in = rsp_ff;
      mid = '0;
      tt = '0;
      fv = '0;
      mag = '0;
      case (st_ff)
         rnpr_pkg::ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            emb_in = 1'b0;
            if (accept) begin
               case (req_data.action)
                  rnpr_pkg::ActLoadA: if (cnt_a_ff < CntW'(MAX_NODES)) begin
                     wa_en = 1'b1;
                     wa_addr = cnt_a_ff[IdxW-1:0];
                     wa_data = {req_data.pos_x, req_data.pos_y, req_data.pos_z,
                                req_data.force_x, req_data.force_y, req_data.force_z};
                     cnt_a_in = cnt_a_ff + 1'b1;
                  end
                  rnpr_pkg::ActLoadB: if (cnt_b_ff < CntW'(MAX_NODES)) begin
                     wb_en = 1'b1;
                     wb_addr = cnt_b_ff[IdxW-1:0];
                     wb_data = {req_data.pos_x, req_data.pos_y, req_data.pos_z,
                                req_data.force_x, req_data.force_y, req_data.force_z};
                     cnt_b_in = cnt_b_ff + 1'b1;
                  end
                  default: ;
               endcase
               if (req_data.action == rnpr_pkg::ActRun && cnt_a_ff == '0)
                  emb_in = 1'b1;
            end
         end
         rnpr_pkg::ST_RD: ;
         rnpr_pkg::ST_DIFF: begin
            // A node stays in na_ff across the inner loop once read
            if (j_ff == '0) na_in = rd_a_ff;
            nb_in = rd_b_ff;
            d_in[0] = 34'(rd_b_ff.px) - 34'((j_ff == '0) ? rd_a_ff.px : na_ff.px);
            d_in[1] = 34'(rd_b_ff.py) - 34'((j_ff == '0) ? rd_a_ff.py : na_ff.py);
            d_in[2] = 34'(rd_b_ff.pz) - 34'((j_ff == '0) ? rd_a_ff.pz : na_ff.pz);
            for (int c = 0; c < 3; c++)
               ad_in[c] = d_in[c][33] ? 33'(-d_in[c]) : d_in[c][32:0];
         end
         rnpr_pkg::ST_SQ:
            for (int c = 0; c < 3; c++)
               sq_in[c] = 50'(ad_ff[c][24:0]) * 50'(ad_ff[c][24:0]);
         rnpr_pkg::ST_SUM:
            dl_in = 52'(sq_ff[0]) + 52'(sq_ff[1]) + 52'(sq_ff[2]);
         rnpr_pkg::ST_CHK: begin
            dv_num = DivW'(52'(ro2_ff) - dl_ff) << 24;
            dv_start = (dl_ff < 52'(ro2_ff)) && !(dl_ff < (52'(minsq_ff) << 24))
                       && (dl_ff >= 52'(ri2_ff));
            sq_start = (dl_ff < 52'(ri2_ff)) && !(dl_ff < (52'(minsq_ff) << 24));
            ax_in = '0;
         end
         rnpr_pkg::ST_DIV: k_in = dv_quo[23:0];
         rnpr_pkg::ST_KSQ: kk_in = 48'(k_ff) * 48'(k_ff);
         rnpr_pkg::ST_SGAIN: s_in = 40'(kk_ff[47:24]) * 40'(gain_ff);
         rnpr_pkg::ST_FMUL: begin
            mag = (64'(ad_ff[ax_ff][24:0]) * 64'(s_ff)) >> 24;
            if (d_ff[ax_ff][33]) fv = -42'(mag);
            else fv = 42'(mag);
            case (ax_ff)
               2'd0: begin
                  na_in.fx = rnpr_pkg::sat_frc(42'(na_ff.fx) - fv);
                  nb_in.fx = rnpr_pkg::sat_frc(42'(nb_ff.fx) + fv);
               end
               2'd1: begin
                  na_in.fy = rnpr_pkg::sat_frc(42'(na_ff.fy) - fv);
                  nb_in.fy = rnpr_pkg::sat_frc(42'(nb_ff.fy) + fv);
               end
               default: begin
                  na_in.fz = rnpr_pkg::sat_frc(42'(na_ff.fz) - fv);
                  nb_in.fz = rnpr_pkg::sat_frc(42'(nb_ff.fz) + fv);
               end
            endcase
            ax_in = ax_ff + 1'b1;
         end
         rnpr_pkg::ST_SQRT: len_in = sq_root;
         rnpr_pkg::ST_CMUL: begin
            cm_in = 58'(ad_ff[ax_ff][24:0]) * 58'(inner_ff);
            dv_num = DivW'(cm_in);
            dv_den = {37'b0, len_ff, 1'b0};
            dv_start = (len_ff != '0);
         end
         rnpr_pkg::ST_CDIV: begin
            dv_den = {37'b0, len_ff, 1'b0};
            if (len_ff == '0 || dv_done) begin
               mag = (len_ff == '0) ? 64'd0 : dv_quo[63:0];
               tt = d_ff[ax_ff][33] ? -34'(mag) : 34'(mag);
               case (ax_ff)
                  2'd0: begin
                     mid = (34'(na_ff.px) + 34'(nb_ff.px)) >>> 1;
                     na_in.px = rnpr_pkg::sat_pos(mid - tt);
                     nb_in.px = rnpr_pkg::sat_pos(mid + tt);
                  end
                  2'd1: begin
                     mid = (34'(na_ff.py) + 34'(nb_ff.py)) >>> 1;
                     na_in.py = rnpr_pkg::sat_pos(mid - tt);
                     nb_in.py = rnpr_pkg::sat_pos(mid + tt);
                  end
                  default: begin
                     mid = (34'(na_ff.pz) + 34'(nb_ff.pz)) >>> 1;
                     na_in.pz = rnpr_pkg::sat_pos(mid - tt);
                     nb_in.pz = rnpr_pkg::sat_pos(mid + tt);
                  end
               endcase
               ax_in = ax_ff + 1'b1;
            end
         end
         rnpr_pkg::ST_WB: begin
            wa_en = 1'b1;
            wb_en = 1'b1;
            // advance the pair; A node's working copy carries to the next j
            if (j_ff == cnt_b_ff - 1'b1) begin
               j_in = '0;
               i_in = (i_ff == cnt_a_ff - 1'b1) ? '0 : i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
            ra_addr = i_in[IdxW-1:0];
            rb_addr = j_in[IdxW-1:0];
         end
         rnpr_pkg::ST_EMIT_RD: ;
         rnpr_pkg::ST_EMIT: begin
            rspv_in = 1'b1;
            if (!emb_ff) begin
               rsp_in = {1'b0, 5'(i_ff), rd_a_ff.px, rd_a_ff.py, rd_a_ff.pz,
                         rd_a_ff.fx, rd_a_ff.fy, rd_a_ff.fz,
                         (cnt_b_ff == '0 && i_ff == cnt_a_ff - 1'b1)};
               if (i_ff == cnt_a_ff - 1'b1) begin
                  emb_in = 1'b1;
                  j_in = '0;
               end else i_in = i_ff + 1'b1;
            end else begin
               rsp_in = {1'b1, 5'(j_ff), rd_b_ff.px, rd_b_ff.py, rd_b_ff.pz,
                         rd_b_ff.fx, rd_b_ff.fy, rd_b_ff.fz,
                         (j_ff == cnt_b_ff - 1'b1)};
               j_in = j_ff + 1'b1;
            end
            if (rsp_in.last) begin
               cnt_a_in = '0;
               cnt_b_in = '0;
            end
            ra_addr = i_in[IdxW-1:0];
            rb_addr = j_in[IdxW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rnpr_pkg::ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         emb_ff <= 1'b0;
         ax_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         i_ff <= i_in;
         j_ff <= j_in;
         emb_ff <= emb_in;
         ax_ff <= ax_in;
         rspv_ff <= rspv_in;
      end
      na_ff <= na_in;
      nb_ff <= nb_in;
      d_ff <= d_in;
      ad_ff <= ad_in;
      sq_ff <= sq_in;
      dl_ff <= dl_in;
      k_ff <= k_in;
      kk_ff <= kk_in;
      s_ff <= s_in;
      len_ff <= len_in;
      cm_ff <= cm_in;
      rsp_ff <= rsp_in;
   end
endmodule

/* rtl/rnpr_divider.sv */
// Restoring divider, one quotient bit per cycle.
// Serves the falloff ratio and the contact offset.
// No dependencies.
module rnpr_divider #(
   parameter int NumW = 64,
   parameter int DenW = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic            done,
   output logic [NumW-1:0] quo
);
   localparam int CntW = $clog2(NumW + 1);

   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0]   r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DenW:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DenW-1:0], q_ff[NumW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one numerator bit into the remainder, subtract if it fits
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

/* rtl/rnpr_sqrt.sv */
// Integer square root, two radicand bits per cycle.
// Used for the contact distance; depends on nothing else.
module rnpr_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [51:0] rad,
   output logic        done,
   output logic [25:0] root
);
   logic [51:0] v_ff, v_in;
   logic [27:0] r_ff, r_in;
   logic [25:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [27:0] trial;
   logic [27:0] rem2;

   always_comb begin
      v_in = v_ff;
      r_in = r_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem2 = {r_ff[25:0], v_ff[51:50]};
      trial = {q_ff, 2'b01};
      if (start) begin
         v_in = rad;
         r_in = '0;
         q_in = '0;
         cnt_in = 5'd26;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[49:0], 2'b00};
         if (rem2 >= trial) begin
            r_in = rem2 - trial;
            q_in = {q_ff[24:0], 1'b1};
         end else begin
            r_in = rem2;
            q_in = {q_ff[24:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign root = q_ff;
endmodule
